>>> hdl/akwb_pkg.sv
// Shared types and constants for the alpha-keyed window blit.
package akwb_pkg;

  // Blob parser state, one-hot.
  typedef enum logic [3:0] {
    PH_WIDTH  = 4'b0001,
    PH_HEIGHT = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_WINDOW_X      = 3'd0;
  localparam logic [2:0] REG_WINDOW_Y      = 3'd1;
  localparam logic [2:0] REG_PLACE_X       = 3'd2;
  localparam logic [2:0] REG_PLACE_Y       = 3'd3;
  localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd4;
  localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd5;
  localparam logic [2:0] REG_FRAME_BASE    = 3'd6;

  // Alpha value that keys a pixel as opaque.
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // A keyed pixel waiting for its address to be formed.
  typedef struct packed {
    logic [31:0] dy;
    logic [31:0] dx;
    logic [31:0] color;
  } hit_t;

endpackage

>>> hdl/alpha_keyed_window_blit_top.sv
// Top level of the alpha-keyed window blit: blob parser, window clip and address pipeline.
//
//   Channel  Dir  Width  Contents
//   s_*      in   32+1   blob word (header or ARGB pixel), start-of-image flag in tuser
//   m_*      out  64     framebuffer write: byte address, then color
//   cfg_*    in   3+32   register index and write data, taken when cfg_write is high
//
// The block takes one word per cycle while the hit register is empty or the output register
// is free. A word is parsed in the cycle it is offered, where the column and row counters
// advance and the window test is made; a keyed pixel is then held in the hit register, goes
// through the address stage (one multiply by the row stride and two adds) and lands in the
// output register. Reset (rst, synchronous) empties both stages and returns the parser to
// wait for a width word. A stall on m_tready holds the output register; input is still taken
// while the address stage is empty.
module alpha_keyed_window_blit_top #(
  parameter int ROW_PIXELS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // Input word stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] blob_word
  input  logic        s_tuser,   // [0] blob_start
  // Framebuffer write stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] write_address, [63:32] write_color
  // Configuration writes.
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [31:0] RowStride = 32'(ROW_PIXELS);

  // Configuration registers.
  logic [15:0] window_x, window_y, place_x, place_y, window_width, window_height;
  logic [31:0] frame_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_x      <= '0;
      window_y      <= '0;
      place_x       <= '0;
      place_y       <= '0;
      window_width  <= '0;
      window_height <= '0;
      frame_base    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        akwb_pkg::REG_WINDOW_X:      window_x      <= cfg_data[15:0];
        akwb_pkg::REG_WINDOW_Y:      window_y      <= cfg_data[15:0];
        akwb_pkg::REG_PLACE_X:       place_x       <= cfg_data[15:0];
        akwb_pkg::REG_PLACE_Y:       place_y       <= cfg_data[15:0];
        akwb_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data[15:0];
        akwb_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data[15:0];
        akwb_pkg::REG_FRAME_BASE:    frame_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The address stage moves whenever the output register is free or
  // being emptied, and the parser takes a word whenever the address stage can take a hit.
  logic hit_valid;
  logic out_free;
  logic accept;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !hit_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  // Parser state.
  akwb_pkg::phase_t phase, phase_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;

  logic [15:0] eff_width, eff_height;
  logic [16:0] x_end, y_end;
  logic [16:0] col_inc, row_inc;
  logic        in_window, keyed, hit;
  akwb_pkg::hit_t hit_data;

  always_comb begin
    eff_width  = (window_width  == '0) ? image_width  : window_width;
    eff_height = (window_height == '0) ? image_height : window_height;
    // Window ends are formed one bit wider so they never wrap.
    x_end     = {1'b0, window_x} + {1'b0, eff_width};
    y_end     = {1'b0, window_y} + {1'b0, eff_height};
    in_window = (column_count >= window_x) && ({1'b0, column_count} < x_end) &&
                (row_count >= window_y) && ({1'b0, row_count} < y_end);
    keyed     = (s_tdata[31:24] == akwb_pkg::ALPHA_OPAQUE);
    col_inc   = {1'b0, column_count} + 17'd1;
    row_inc   = {1'b0, row_count} + 17'd1;

    hit_data.dy    = 32'(place_y) - 32'(window_y) + 32'(row_count);
    hit_data.dx    = 32'(place_x) - 32'(window_x) + 32'(column_count);
    hit_data.color = s_tdata;

    phase_next        = phase;
    image_width_next  = image_width;
    image_height_next = image_height;
    column_count_next = column_count;
    row_count_next    = row_count;
    hit               = 1'b0;

    if (s_tuser || phase == akwb_pkg::PH_WIDTH) begin
      // A start flag always opens a new image, abandoning any image in progress.
      image_width_next  = s_tdata[15:0];
      column_count_next = '0;
      row_count_next    = '0;
      phase_next        = akwb_pkg::PH_HEIGHT;
    end else begin
      case (phase)
        akwb_pkg::PH_HEIGHT: begin
          image_height_next = s_tdata[15:0];
          column_count_next = '0;
          row_count_next    = '0;
          // An empty image has no pixels to count.
          phase_next = (image_width == '0 || s_tdata[15:0] == '0) ?
                       akwb_pkg::PH_DONE : akwb_pkg::PH_PIXELS;
        end
        akwb_pkg::PH_PIXELS: begin
          hit = in_window && keyed;
          if (col_inc >= {1'b0, image_width}) begin
            column_count_next = '0;
            if (row_inc >= {1'b0, image_height}) begin
              row_count_next = '0;
              phase_next     = akwb_pkg::PH_DONE;
            end else begin
              row_count_next = row_inc[15:0];
            end
          end else begin
            column_count_next = col_inc[15:0];
          end
        end
        default: ;  // Words after the image end are dropped.
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= akwb_pkg::PH_WIDTH;
      image_width  <= '0;
      image_height <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Hit register between the parser and the address stage.
  akwb_pkg::hit_t hit_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (s_tready) begin
      hit_valid <= accept && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hit) begin
      hit_reg <= hit_data;
    end
  end

  // Address stage: pixel index times four plus the base, all modulo 2^32.
  logic [31:0] pixel_index;
  logic [31:0] address;

  always_comb begin
    pixel_index = hit_reg.dy * RowStride + hit_reg.dx;
    address     = frame_base + {pixel_index[29:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && hit_valid) begin
      m_tdata <= {hit_reg.color, address};
    end
  end

endmodule
